// File: rtl/core/rpl_pkg.sv
// Shared types, character codes and token codes of the route pattern lexer.
package rpl_pkg;

   localparam int MAX_RESULTS = 3;

   // Pattern characters with a meaning of their own.
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_QUEST  = 8'h3F;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_UNDER  = 8'h5F;

   // Token kinds.
   localparam logic [2:0] K_MOD   = 3'd0;
   localparam logic [2:0] K_ESC   = 3'd1;
   localparam logic [2:0] K_OPEN  = 3'd2;
   localparam logic [2:0] K_CLOSE = 3'd3;
   localparam logic [2:0] K_NAME  = 3'd4;
   localparam logic [2:0] K_PAT   = 3'd5;
   localparam logic [2:0] K_CHAR  = 3'd6;
   localparam logic [2:0] K_END   = 3'd7;

   // Error codes.
   localparam logic [2:0] ERR_NONE     = 3'd0;
   localparam logic [2:0] ERR_QSTART   = 3'd1;
   localparam logic [2:0] ERR_UNBAL    = 3'd2;
   localparam logic [2:0] ERR_EMPTY    = 3'd3;
   localparam logic [2:0] ERR_DANGLING = 3'd4;
   localparam logic [2:0] ERR_TOO_DEEP = 3'd5;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } rpl_req_type;

   typedef struct packed {
      logic [2:0] token_kind;
      logic [7:0] token_byte;
      logic       byte_valid;
      logic       token_first;
      logic       token_final;
      logic [2:0] error_code;
      logic       run_last;
   } rpl_rsp_type;

   // All results caused by one input word, slot 0 first.
   typedef struct packed {
      rpl_rsp_type [MAX_RESULTS-1:0] res;
      logic [1:0]                    cnt;
   } rpl_bundle_type;

   typedef struct packed {
      logic full;
      logic empty;
   } rpl_qstat_type;

   function automatic rpl_rsp_type make_rsp(input logic [2:0] kind, input logic [7:0] byte_v,
                                            input logic valid, input logic first,
                                            input logic fin, input logic [2:0] err);
      rpl_rsp_type r;
      r.token_kind  = kind;
      r.token_byte  = valid ? byte_v : 8'h00;
      r.byte_valid  = valid;
      r.token_first = first;
      r.token_final = fin;
      r.error_code  = err;
      r.run_last    = 1'b0;
      return r;
   endfunction

   function automatic logic is_name_char(input logic [7:0] c);
      return c inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39], CH_UNDER};
   endfunction

endpackage

// File: rtl/core/rpl_front.sv
// Front end: accepts pattern words, tracks lexer mode and group depth, builds result bundles.
module rpl_front
   import rpl_pkg::*;
#(
   parameter int MAX_GROUP_DEPTH = 15
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  rpl_req_type    req_word,
   input  rpl_qstat_type  q_stat,
   output logic           q_push,
   output rpl_bundle_type q_bundle
);

   localparam int DEPTH_W = $clog2(MAX_GROUP_DEPTH + 1);
   localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(MAX_GROUP_DEPTH);
   localparam logic [DEPTH_W-1:0] DEPTH_ONE = DEPTH_W'(1);

   localparam logic [2:0] M_NORMAL     = 3'd0;
   localparam logic [2:0] M_ESC        = 3'd1;
   localparam logic [2:0] M_NAME_EMPTY = 3'd2;
   localparam logic [2:0] M_NAME_MORE  = 3'd3;
   localparam logic [2:0] M_GROUP_OPEN = 3'd4;
   localparam logic [2:0] M_GROUP      = 3'd5;
   localparam logic [2:0] M_GROUP_ESC  = 3'd6;
   localparam logic [2:0] M_SKIP       = 3'd7;

   logic [2:0]         mode_ff, mode_in;
   logic [DEPTH_W-1:0] depth_ff, depth_in;
   logic               accept;
   logic [1:0]         n_v;
   logic [2:0]         err_v;
   logic               pending;
   logic               first_v;
   rpl_rsp_type [MAX_RESULTS-1:0] res_v;

   assign req_ready = !q_stat.full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      mode_in  = mode_ff;
      depth_in = depth_ff;
      n_v      = 2'd0;
      err_v    = ERR_NONE;
      pending  = 1'b1;
      first_v  = 1'b0;
      res_v    = '0;
      if (mode_ff == M_SKIP) begin
         // drop everything up to the word marked last
         if (req_word.last) begin
            mode_in = M_NORMAL;
         end
      end else begin
         case (mode_ff)
            M_NAME_EMPTY, M_NAME_MORE: begin
               first_v = (mode_ff == M_NAME_EMPTY);
               if (is_name_char(req_word.ch)) begin
                  res_v[n_v] = make_rsp(K_NAME, req_word.ch, 1'b1, first_v, 1'b0, ERR_NONE);
                  n_v        = n_v + 2'd1;
                  mode_in    = M_NAME_MORE;
               end else begin
                  res_v[n_v] = make_rsp(K_NAME, 8'h00, 1'b0, first_v, 1'b1, ERR_NONE);
                  n_v        = n_v + 2'd1;
                  mode_in    = M_NORMAL;
               end
            end
            M_ESC: begin
               res_v[n_v] = make_rsp(K_ESC, req_word.ch, 1'b1, 1'b1, 1'b1, ERR_NONE);
               n_v        = n_v + 2'd1;
               mode_in    = M_NORMAL;
               pending    = 1'b0;
            end
            M_GROUP_ESC: begin
               res_v[n_v] = make_rsp(K_PAT, req_word.ch, 1'b1, 1'b0, 1'b0, ERR_NONE);
               n_v        = n_v + 2'd1;
               mode_in    = M_GROUP;
            end
            M_GROUP_OPEN, M_GROUP: begin
               first_v = (mode_ff == M_GROUP_OPEN);
               if (first_v && req_word.ch == CH_QUEST) begin
                  err_v = ERR_QSTART;
               end else if (req_word.ch == CH_BSLASH) begin
                  res_v[n_v] = make_rsp(K_PAT, req_word.ch, 1'b1, first_v, 1'b0, ERR_NONE);
                  n_v        = n_v + 2'd1;
                  mode_in    = M_GROUP_ESC;
               end else if (req_word.ch == CH_RPAREN) begin
                  if (depth_ff != '0) begin
                     depth_in = depth_ff - DEPTH_ONE;
                  end
                  if (depth_in == '0) begin
                     if (first_v) begin
                        err_v = ERR_EMPTY;
                     end else begin
                        // outer parenthesis closes the pattern token
                        res_v[n_v] = make_rsp(K_PAT, 8'h00, 1'b0, 1'b0, 1'b1, ERR_NONE);
                        n_v        = n_v + 2'd1;
                        mode_in    = M_NORMAL;
                        pending    = 1'b0;
                     end
                  end else begin
                     res_v[n_v] = make_rsp(K_PAT, req_word.ch, 1'b1, first_v, 1'b0, ERR_NONE);
                     n_v        = n_v + 2'd1;
                     mode_in    = M_GROUP;
                  end
               end else if (req_word.ch == CH_LPAREN) begin
                  if (depth_ff >= DEPTH_MAX) begin
                     err_v = ERR_TOO_DEEP;
                  end else begin
                     depth_in   = depth_ff + DEPTH_ONE;
                     res_v[n_v] = make_rsp(K_PAT, req_word.ch, 1'b1, first_v, 1'b0, ERR_NONE);
                     n_v        = n_v + 2'd1;
                     mode_in    = M_GROUP;
                  end
               end else begin
                  res_v[n_v] = make_rsp(K_PAT, req_word.ch, 1'b1, first_v, 1'b0, ERR_NONE);
                  n_v        = n_v + 2'd1;
                  mode_in    = M_GROUP;
               end
            end
            default: begin
            end
         endcase

         // lex the word in normal mode, also right after a name closed
         if (err_v == ERR_NONE && mode_in == M_NORMAL && pending) begin
            case (req_word.ch)
               CH_STAR, CH_PLUS, CH_QUEST: begin
                  res_v[n_v] = make_rsp(K_MOD, req_word.ch, 1'b1, 1'b1, 1'b1, ERR_NONE);
                  n_v        = n_v + 2'd1;
               end
               CH_BSLASH: begin
                  mode_in = M_ESC;
               end
               CH_LBRACE: begin
                  res_v[n_v] = make_rsp(K_OPEN, req_word.ch, 1'b1, 1'b1, 1'b1, ERR_NONE);
                  n_v        = n_v + 2'd1;
               end
               CH_RBRACE: begin
                  res_v[n_v] = make_rsp(K_CLOSE, req_word.ch, 1'b1, 1'b1, 1'b1, ERR_NONE);
                  n_v        = n_v + 2'd1;
               end
               CH_COLON: begin
                  mode_in = M_NAME_EMPTY;
               end
               CH_LPAREN: begin
                  mode_in  = M_GROUP_OPEN;
                  depth_in = DEPTH_ONE;
               end
               default: begin
                  res_v[n_v] = make_rsp(K_CHAR, req_word.ch, 1'b1, 1'b1, 1'b1, ERR_NONE);
                  n_v        = n_v + 2'd1;
               end
            endcase
         end

         // close out the pattern on its final word
         if (err_v == ERR_NONE && req_word.last) begin
            case (mode_in)
               M_NORMAL: begin
               end
               M_NAME_EMPTY, M_NAME_MORE: begin
                  res_v[n_v] = make_rsp(K_NAME, 8'h00, 1'b0, mode_in == M_NAME_EMPTY, 1'b1,
                                        ERR_NONE);
                  n_v        = n_v + 2'd1;
               end
               M_ESC, M_GROUP_ESC: begin
                  err_v = ERR_DANGLING;
               end
               default: begin
                  err_v = ERR_UNBAL;
               end
            endcase
            if (err_v == ERR_NONE) begin
               res_v[n_v] = make_rsp(K_END, 8'h00, 1'b0, 1'b1, 1'b1, ERR_NONE);
               n_v        = n_v + 2'd1;
            end
         end

         if (err_v != ERR_NONE) begin
            res_v[n_v] = make_rsp(K_END, 8'h00, 1'b0, 1'b1, 1'b1, err_v);
            n_v        = n_v + 2'd1;
            depth_in   = '0;
            mode_in    = req_word.last ? M_NORMAL : M_SKIP;
         end else if (req_word.last) begin
            mode_in  = M_NORMAL;
            depth_in = '0;
         end
      end

      if (n_v != 2'd0) begin
         res_v[n_v - 2'd1].run_last = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= M_NORMAL;
         depth_ff <= '0;
      end else if (accept) begin
         mode_ff  <= mode_in;
         depth_ff <= depth_in;
      end
   end

   assign q_push       = accept && (n_v != 2'd0);
   assign q_bundle.res = res_v;
   assign q_bundle.cnt = n_v;

   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= DEPTH_MAX)
      else $error("group depth above limit");

   a_skip_silent: assert property (@(posedge clock) disable iff (reset)
      accept && mode_ff == M_SKIP |-> !q_push)
      else $error("result produced while skipping a failed pattern");

   a_last_resets: assert property (@(posedge clock) disable iff (reset)
      accept && req_word.last |=> mode_ff == M_NORMAL && depth_ff == '0)
      else $error("lexer state not cleared after final word");

endmodule

// File: rtl/core/rpl_queue.sv
// Short queue of result bundles between the front and back ends.
module rpl_queue
   import rpl_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  rpl_bundle_type push_data,
   input  logic           pop,
   output rpl_bundle_type pop_data,
   output rpl_qstat_type  stat
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   rpl_bundle_type     slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign stat.full  = (count_ff == CNT_FULL);
   assign stat.empty = (count_ff == '0);
   assign pop_data   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !stat.full)
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !stat.empty)
      else $error("pop from empty queue");

   a_count_track: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> count_ff == $past(count_ff) + CNT_W'($past(push))
                                    - CNT_W'($past(pop)))
      else $error("queue count out of step with push and pop");

endmodule

// File: rtl/core/rpl_back.sv
// Back end: walks each bundle into the output register, one word per cycle when not stalled.
module rpl_back
   import rpl_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  rpl_qstat_type  q_stat,
   input  rpl_bundle_type q_head,
   output logic           q_pop,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output rpl_rsp_type    rsp_word
);

   logic        valid_ff, valid_in;
   rpl_rsp_type word_ff;
   logic [1:0]  idx_ff, idx_in;
   logic        load;
   logic        at_end;

   assign load   = (!valid_ff || rsp_ready) && !q_stat.empty;
   assign at_end = (idx_ff == q_head.cnt - 2'd1);
   assign q_pop  = load && at_end;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = at_end ? 2'd0 : idx_ff + 2'd1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= q_head.res[idx_ff];
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_word  = word_ff;

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      !q_stat.empty |-> idx_ff < q_head.cnt)
      else $error("slot index past bundle count");

   a_idle_idx: assert property (@(posedge clock) disable iff (reset)
      q_stat.empty |-> idx_ff == 2'd0)
      else $error("slot index left mid-bundle with queue empty");

   a_error_is_last: assert property (@(posedge clock) disable iff (reset)
      valid_ff && word_ff.error_code != ERR_NONE |-> word_ff.run_last && word_ff.token_final)
      else $error("error word not closing its run");

endmodule

// File: rtl/core/route_pattern_lexer.sv
// Top level of the streaming route pattern lexer.
//
// Usage:
//   req channel: one pattern byte per word (req_word.ch) with req_word.last on the
//   final byte. req_ready is high whenever the bundle queue has room, so a byte can
//   be taken every cycle until a stall on the result side fills the queue.
//   rsp channel: token words, one per cycle while rsp_ready is high, each with kind,
//   text byte, first/final token marks, error code and run_last on the last word
//   caused by an input byte. A byte yields zero to three words.
// The words of a byte pass through the bundle queue and then the output register.
// Throughput: one byte per cycle while each byte yields at most one word and rsp_ready
//   stays high; the output register moves one word per cycle while rsp_ready is high, so
//   bytes that yield two or three words hold the result side longer, and the front keeps
//   taking bytes until the QUEUE_DEPTH-entry bundle queue fills.
// Reset: clears lexer mode, group depth, queue pointers and the output valid.
// Receiver stall: rsp_word holds while rsp_ready is low; the queue absorbs bytes
//   until full, then req_ready drops.
// After an error word, bytes are dropped up to and including the last-marked one.
module route_pattern_lexer
   import rpl_pkg::*;
#(
   parameter int MAX_GROUP_DEPTH = 15,
   parameter int QUEUE_DEPTH     = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  rpl_req_type req_word,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rpl_rsp_type rsp_word
);

   rpl_qstat_type  q_stat;
   logic           q_push;
   logic           q_pop;
   rpl_bundle_type q_push_data;
   rpl_bundle_type q_head;

   // front: classify each byte and build its result bundle
   rpl_front #(
      .MAX_GROUP_DEPTH(MAX_GROUP_DEPTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .q_stat    (q_stat),
      .q_push    (q_push),
      .q_bundle  (q_push_data)
   );

   // decouple the two sides
   rpl_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .pop_data  (q_head),
      .stat      (q_stat)
   );

   // back: serialize bundles into result words
   rpl_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_stat    (q_stat),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

endmodule

// File: bench/tb.sv
// Self-checking testbench for the route pattern lexer: directed, pressure and random patterns.
`timescale 1ns / 1ps

module tb;
   import rpl_pkg::*;

   localparam int GROUP_LIMIT = 15;
   // Watchdog bound, sized for the slowest run with idle gaps, receiver stalls and long holds.
   localparam int CYCLE_LIMIT = 500000;
   localparam int RANDOM_BYTES = 300;
   localparam int SETTLE_CYCLES = 12;
   localparam int MAX_REPORTS = 40;

   // Lexer modes of the predictor.
   typedef enum logic [2:0] {
      SM_NORMAL, SM_ESC, SM_NAME_EMPTY, SM_NAME_MORE,
      SM_GROUP_OPEN, SM_GROUP, SM_GROUP_ESC, SM_SKIP
   } scan_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   rpl_req_type req_word = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rpl_rsp_type rsp_word;

   // Predictor state and the words it still waits for.
   scan_mode_type scan_mode = SM_NORMAL;
   int          nest_level = 0;
   int          words_this_byte;
   rpl_rsp_type token_q[$];

   // Stimulus controls shared by the sender, the receiver and the tests.
   logic [7:0]  pattern_q[$];
   bit          tx_idle_on = 1'b1;
   bit          rx_idle_on = 1'b1;
   int          hold_rsp_cycles = 0;

   // Bookkeeping.
   int          cycle_count = 0;
   int          mismatch_count = 0;
   int          bytes_sent = 0;
   int          bytes_lexed = 0;
   int          words_checked = 0;
   int          err_seen[8];

   route_pattern_lexer #(.MAX_GROUP_DEPTH(GROUP_LIMIT)) i_dut (
      .clock,
      .reset,
      .req_valid,
      .req_ready,
      .req_word,
      .rsp_valid,
      .rsp_ready,
      .rsp_word
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog: end the run if the block hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
                  token_q.size());
         $display("route_pattern_lexer test failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------

   function automatic logic is_route_name_byte(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
             (c >= 8'h30 && c <= 8'h39) || c == CH_UNDER;
   endfunction

   // Append one expected word; marker-only words carry a zero byte.
   function automatic void queue_token(input logic [2:0] kind, input logic [7:0] b,
                                       input logic v, input logic first,
                                       input logic fin, input logic [2:0] err);
      rpl_rsp_type w;
      w.token_kind  = kind;
      w.token_byte  = v ? b : 8'h00;
      w.byte_valid  = v;
      w.token_first = first;
      w.token_final = fin;
      w.error_code  = err;
      w.run_last    = 1'b0;
      token_q.push_back(w);
      words_this_byte++;
   endfunction

   // Advance the lexer by one pattern byte and queue the words it yields.
   function automatic void lex_byte(input rpl_req_type w);
      logic [7:0] c;
      logic       consumed;
      logic       first;
      logic [2:0] err;
      c = w.ch;
      consumed = 1'b0;
      err = ERR_NONE;
      words_this_byte = 0;

      // After an error, drop bytes through the last-marked one.
      if (scan_mode == SM_SKIP) begin
         if (w.last) begin
            scan_mode = SM_NORMAL;
            nest_level = 0;
         end
         return;
      end
      bytes_lexed++;

      case (scan_mode)
         SM_NAME_EMPTY, SM_NAME_MORE: begin
            first = (scan_mode == SM_NAME_EMPTY);
            if (is_route_name_byte(c)) begin
               queue_token(K_NAME, c, 1'b1, first, 1'b0, ERR_NONE);
               scan_mode = SM_NAME_MORE;
            end else begin
               // close the name; the byte is lexed normally below
               queue_token(K_NAME, 8'h00, 1'b0, first, 1'b1, ERR_NONE);
               scan_mode = SM_NORMAL;
            end
         end
         SM_ESC: begin
            queue_token(K_ESC, c, 1'b1, 1'b1, 1'b1, ERR_NONE);
            scan_mode = SM_NORMAL;
            consumed = 1'b1;
         end
         SM_GROUP_ESC: begin
            queue_token(K_PAT, c, 1'b1, 1'b0, 1'b0, ERR_NONE);
            scan_mode = SM_GROUP;
         end
         SM_GROUP_OPEN, SM_GROUP: begin
            first = (scan_mode == SM_GROUP_OPEN);
            if (first && c == CH_QUEST) begin
               err = ERR_QSTART;
            end else if (c == CH_BSLASH) begin
               queue_token(K_PAT, c, 1'b1, first, 1'b0, ERR_NONE);
               scan_mode = SM_GROUP_ESC;
            end else if (c == CH_RPAREN) begin
               if (nest_level > 0) nest_level--;
               if (nest_level == 0) begin
                  if (first) begin
                     err = ERR_EMPTY;
                  end else begin
                     // outer parenthesis closes the token and is not streamed
                     queue_token(K_PAT, 8'h00, 1'b0, 1'b0, 1'b1, ERR_NONE);
                     scan_mode = SM_NORMAL;
                     consumed = 1'b1;
                  end
               end else begin
                  queue_token(K_PAT, c, 1'b1, first, 1'b0, ERR_NONE);
                  scan_mode = SM_GROUP;
               end
            end else if (c == CH_LPAREN) begin
               if (nest_level >= GROUP_LIMIT) begin
                  err = ERR_TOO_DEEP;
               end else begin
                  nest_level++;
                  queue_token(K_PAT, c, 1'b1, first, 1'b0, ERR_NONE);
                  scan_mode = SM_GROUP;
               end
            end else begin
               queue_token(K_PAT, c, 1'b1, first, 1'b0, ERR_NONE);
               scan_mode = SM_GROUP;
            end
         end
         default: ;
      endcase

      if (err == ERR_NONE && scan_mode == SM_NORMAL && !consumed) begin
         if (c == CH_STAR || c == CH_PLUS || c == CH_QUEST)
            queue_token(K_MOD, c, 1'b1, 1'b1, 1'b1, ERR_NONE);
         else if (c == CH_BSLASH)
            scan_mode = SM_ESC;
         else if (c == CH_LBRACE)
            queue_token(K_OPEN, c, 1'b1, 1'b1, 1'b1, ERR_NONE);
         else if (c == CH_RBRACE)
            queue_token(K_CLOSE, c, 1'b1, 1'b1, 1'b1, ERR_NONE);
         else if (c == CH_COLON)
            scan_mode = SM_NAME_EMPTY;
         else if (c == CH_LPAREN) begin
            scan_mode = SM_GROUP_OPEN;
            nest_level = 1;
         end else
            queue_token(K_CHAR, c, 1'b1, 1'b1, 1'b1, ERR_NONE);
      end

      // Final byte: close an open name, or flag what is left hanging.
      if (err == ERR_NONE && w.last) begin
         case (scan_mode)
            SM_NORMAL: ;
            SM_NAME_EMPTY, SM_NAME_MORE:
               queue_token(K_NAME, 8'h00, 1'b0, scan_mode == SM_NAME_EMPTY, 1'b1, ERR_NONE);
            SM_ESC, SM_GROUP_ESC: err = ERR_DANGLING;
            default: err = ERR_UNBAL;
         endcase
         if (err == ERR_NONE) queue_token(K_END, 8'h00, 1'b0, 1'b1, 1'b1, ERR_NONE);
      end

      if (err != ERR_NONE) begin
         queue_token(K_END, 8'h00, 1'b0, 1'b1, 1'b1, err);
         nest_level = 0;
         if (w.last)
            scan_mode = SM_NORMAL;
         else
            scan_mode = SM_SKIP;
      end else if (w.last) begin
         scan_mode = SM_NORMAL;
         nest_level = 0;
      end

      if (words_this_byte > 0) token_q[token_q.size() - 1].run_last = 1'b1;
   endfunction

   // ------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------

   task automatic report_mismatch(input string msg);
      if (mismatch_count < MAX_REPORTS) $display("cycle %0d: %s", cycle_count, msg);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input int got, input int want);
      if (got != want)
         report_mismatch($sformatf("%s is %0d, want %0d", name, got, want));
   endtask

   task automatic check_token(input rpl_rsp_type got);
      rpl_rsp_type want;
      if (token_q.size() == 0) begin
         report_mismatch($sformatf("word %h with nothing expected", got));
         return;
      end
      want = token_q.pop_front();
      words_checked++;
      err_seen[want.error_code]++;
      check_field("token_kind", int'(got.token_kind), int'(want.token_kind));
      check_field("token_byte", int'(got.token_byte), int'(want.token_byte));
      check_field("byte_valid", int'(got.byte_valid), int'(want.byte_valid));
      check_field("token_first", int'(got.token_first), int'(want.token_first));
      check_field("token_final", int'(got.token_final), int'(want.token_final));
      check_field("error_code", int'(got.error_code), int'(want.error_code));
      check_field("run_last", int'(got.run_last), int'(want.run_last));
   endtask

   // Check the outgoing word before predicting the incoming one: a byte's
   // words can never leave in the cycle it is taken.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) check_token(rsp_word);
         if (req_valid && req_ready) lex_byte(req_word);
      end
   end

   // ------------------------------------------------------------------
   // Receiver: per word draw a stall; honor a long hold when one is asked.
   // ------------------------------------------------------------------

   initial begin : rsp_side
      int stall;
      forever begin
         if (hold_rsp_cycles > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold_rsp_cycles) @(posedge clock);
            hold_rsp_cycles = 0;
         end
         stall = rx_idle_on ? $urandom_range(0, 17) : 0;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid && hold_rsp_cycles == 0);
      end
   end

   // ------------------------------------------------------------------
   // Sender and pattern builders
   // ------------------------------------------------------------------

   // Offer one word and hold it until taken; valid stays up when no gap is drawn.
   task automatic send_byte(input logic [7:0] c, input logic fin);
      int gap;
      gap = tx_idle_on ? $urandom_range(0, 17) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= '{ch: c, last: fin};
      do @(posedge clock); while (!req_ready);
      bytes_sent++;
   endtask

   task automatic send_pattern();
      for (int i = 0; i < pattern_q.size(); i++)
         send_byte(pattern_q[i], i == pattern_q.size() - 1);
      pattern_q.delete();
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) pattern_q.push_back(s[i]);
   endtask

   // Hold the sender until every expected word is back, then let the tail settle.
   // The first edge lets the predictor take in the byte accepted last.
   task automatic wait_for_tokens();
      req_valid <= 1'b0;
      @(posedge clock);
      while (token_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One piece of group text: mostly a printable byte, sometimes an escape pair.
   task automatic push_group_fill();
      logic [7:0] b;
      if ($urandom_range(0, 4) == 0) begin
         pattern_q.push_back(CH_BSLASH);
         pattern_q.push_back(8'($urandom_range(0, 255)));
      end else begin
         do b = 8'($urandom_range(8'h20, 8'h7E));
         while (b == CH_LPAREN || b == CH_RPAREN || b == CH_BSLASH || b == CH_QUEST);
         pattern_q.push_back(b);
      end
   endtask

   task automatic push_group(input int levels);
      for (int l = 0; l < levels; l++) begin
         pattern_q.push_back(CH_LPAREN);
         repeat ($urandom_range(1, 2)) push_group_fill();
      end
      for (int l = 0; l < levels; l++) begin
         if ($urandom_range(0, 1)) push_group_fill();
         pattern_q.push_back(CH_RPAREN);
      end
   endtask

   // Mostly well-formed route with random content; a few broken on purpose.
   task automatic build_route();
      int pieces;
      int levels;
      int cut;
      pieces = $urandom_range(1, 8);
      repeat (pieces) begin
         case ($urandom_range(0, 13))
            0, 1, 2: pattern_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
            3: begin
               case ($urandom_range(0, 2))
                  0: pattern_q.push_back(CH_STAR);
                  1: pattern_q.push_back(CH_PLUS);
                  default: pattern_q.push_back(CH_QUEST);
               endcase
            end
            4: pattern_q.push_back($urandom_range(0, 1) ? CH_LBRACE : CH_RBRACE);
            5: begin
               pattern_q.push_back(CH_BSLASH);
               pattern_q.push_back(8'($urandom_range(0, 255)));
            end
            6, 7: begin
               pattern_q.push_back(CH_COLON);
               repeat ($urandom_range(0, 6)) begin
                  case ($urandom_range(0, 3))
                     0: pattern_q.push_back(8'($urandom_range(8'h61, 8'h7A)));
                     1: pattern_q.push_back(8'($urandom_range(8'h41, 8'h5A)));
                     2: pattern_q.push_back(8'($urandom_range(8'h30, 8'h39)));
                     default: pattern_q.push_back(CH_UNDER);
                  endcase
               end
            end
            8, 9, 10: begin
               // now and then nest right up to and past the depth limit
               levels = ($urandom_range(0, 15) == 0) ? $urandom_range(13, 17)
                                                     : $urandom_range(1, 3);
               push_group(levels);
            end
            11: pattern_q.push_back(8'($urandom_range(0, 255)));
            12: begin
               pattern_q.push_back(CH_LPAREN);
               pattern_q.push_back(CH_RPAREN);
            end
            default: begin
               pattern_q.push_back(CH_LPAREN);
               pattern_q.push_back(CH_QUEST);
            end
         endcase
      end
      // truncate some routes to leave a group or an escape hanging
      if (pattern_q.size() > 1 && $urandom_range(0, 9) == 0) begin
         cut = $urandom_range(1, pattern_q.size() - 1);
         repeat (cut) void'(pattern_q.pop_back());
      end else if ($urandom_range(0, 19) == 0) begin
         pattern_q.push_back(CH_BSLASH);
      end
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Byte extremes and every one-byte token kind.
   task automatic test_single_byte_tokens();
      pattern_q.push_back(8'h00);
      push_text("*+?{}a");
      pattern_q.push_back(8'hFF);
      send_pattern();
      wait_for_tokens();
   endtask

   // Escape outside a group, a name ended by a plain char, an empty name at the end.
   task automatic test_escape_and_name();
      push_text("\\(:a_Z9)");
      send_pattern();
      push_text(":");
      send_pattern();
      wait_for_tokens();
   endtask

   // Error cases: ? opening a group, empty group (then skip), unbalanced, dangling escape.
   task automatic test_error_cases();
      push_text("(?");
      send_pattern();
      push_text("()x");
      send_pattern();
      push_text("(");
      send_pattern();
      push_text("\\");
      send_pattern();
      wait_for_tokens();
   endtask

   // Nest exactly to the limit, then one level past it.
   task automatic test_group_depth();
      repeat (GROUP_LIMIT) pattern_q.push_back(CH_LPAREN);
      push_text("x");
      repeat (GROUP_LIMIT) pattern_q.push_back(CH_RPAREN);
      send_pattern();
      repeat (GROUP_LIMIT + 1) pattern_q.push_back(CH_LPAREN);
      push_text("yz");
      send_pattern();
      wait_for_tokens();
   endtask

   // Hold the result side while bytes keep coming, so the block fills and stalls.
   task automatic test_full_queue();
      tx_idle_on = 1'b0;
      hold_rsp_cycles = 80;
      repeat (8) push_text(":ab-");
      send_pattern();
      wait_for_tokens();
      tx_idle_on = 1'b1;
   endtask

   task automatic test_random_patterns();
      int target;
      target = bytes_sent + RANDOM_BYTES;
      while (bytes_sent < target) begin
         // switch idling on and off in stretches
         if ($urandom_range(0, 7) == 0) tx_idle_on = !tx_idle_on;
         if ($urandom_range(0, 7) == 0) rx_idle_on = !rx_idle_on;
         if ($urandom_range(0, 6) == 0) begin
            repeat ($urandom_range(1, 10)) pattern_q.push_back(8'($urandom_range(0, 255)));
         end else begin
            build_route();
         end
         send_pattern();
      end
      wait_for_tokens();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_single_byte_tokens();
      test_escape_and_name();
      test_error_cases();
      test_group_depth();
      test_full_queue();
      test_random_patterns();

      $display("covered %0d pattern bytes (%0d lexed), %0d token words checked",
               bytes_sent, bytes_lexed, words_checked);
      $display("error words: qstart %0d unbalanced %0d empty %0d dangling %0d too-deep %0d",
               err_seen[ERR_QSTART], err_seen[ERR_UNBAL], err_seen[ERR_EMPTY],
               err_seen[ERR_DANGLING], err_seen[ERR_TOO_DEEP]);
      if (mismatch_count == 0)
         $display("route_pattern_lexer test passed");
      else
         $display("route_pattern_lexer test failed");
      $finish;
   end

endmodule
